// File: src/civ_pkg.sv
// civ_pkg: shared types and constants of the cyclic index vector.
// Holds the transaction payload structs, operation codes and status codes.
// Depends on nothing; every other file of the block refers to it by scoped names.
package civ_pkg;

    // Field widths fixed by the transaction formats.
    localparam int DATA_W = 32;
    localparam int LEN_W  = 7;
    localparam int OP_W   = 3;
    localparam int STAT_W = 2;

    // Default store depth and length after reset.
    localparam int CAPACITY_DEF = 64;
    localparam int LEN_RESET    = 8;

    // Operation codes; the remaining codes do nothing.
    localparam logic [OP_W-1:0] OP_SET    = 3'd0;
    localparam logic [OP_W-1:0] OP_GET    = 3'd1;
    localparam logic [OP_W-1:0] OP_INSERT = 3'd2;
    localparam logic [OP_W-1:0] OP_DELETE = 3'd3;
    localparam logic [OP_W-1:0] OP_FILL   = 3'd4;

    // Status codes.
    localparam logic [STAT_W-1:0] ST_OK   = 2'd0;
    localparam logic [STAT_W-1:0] ST_NEG  = 2'd1;
    localparam logic [STAT_W-1:0] ST_LAST = 2'd2;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd3;

    // Input transaction.
    typedef struct packed {
        logic [OP_W-1:0]          op;
        logic signed [DATA_W-1:0] index;
        logic signed [DATA_W-1:0] value;
    } in_item_t;

    // Result transaction.
    typedef struct packed {
        logic signed [DATA_W-1:0] read_value;
        logic [LEN_W-1:0]         current_length;
        logic [STAT_W-1:0]        status;
    } out_item_t;

endpackage

// File: src/civ_mod.sv
// civ_mod: iterative unsigned modulo, one quotient bit per cycle.
// Reduces a 32-bit index by the current length (restoring division).
// Depends on civ_pkg for the data width.
module civ_mod #(
    parameter int LW = 7
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    input  logic [civ_pkg::DATA_W-1:0] dividend,
    input  logic [LW-1:0]             divisor,
    output logic                      done,
    output logic [LW-1:0]             remainder
);

    localparam int CNT_W = $clog2(civ_pkg::DATA_W);

    logic              busy_reg;
    logic              done_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic [LW-1:0]     rem_reg;
    logic [civ_pkg::DATA_W-1:0] dvd_reg;

    logic [LW:0] trial;
    logic [LW:0] diff;
    logic [LW-1:0] rem_next;

    // One restoring step: bring down the next dividend bit and subtract if it fits.
    always_comb
    begin
        trial    = {rem_reg, dvd_reg[civ_pkg::DATA_W-1]};
        diff     = trial - {1'b0, divisor};
        rem_next = (trial >= {1'b0, divisor}) ? diff[LW-1:0] : trial[LW-1:0];
    end

    // Control state of the iteration.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + CNT_W'(1);
                if (cnt_reg == CNT_W'(civ_pkg::DATA_W - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Partial remainder and dividend shift register.
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rem_reg <= '0;
            dvd_reg <= dividend;
        end
        else if (busy_reg)
        begin
            rem_reg <= rem_next;
            dvd_reg <= {dvd_reg[civ_pkg::DATA_W-2:0], 1'b0};
        end
    end

    assign done      = done_reg;
    assign remainder = rem_reg;

endmodule

// File: src/civ_core.sv
// civ_core: operation sequencer around the entry memory of the cyclic index vector.
// Holds the store, the length in use, the clearing pass and the shift sequences.
// Depends on civ_pkg and instantiates civ_mod for the index reduction.
module civ_core #(
    parameter int CAPACITY = civ_pkg::CAPACITY_DEF
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cfg_we,
    input  logic [civ_pkg::LEN_W-1:0] cfg_len,
    input  logic                     req_valid,
    output logic                     req_ready,
    input  civ_pkg::in_item_t        req,
    output logic                     resp_valid,
    input  logic                     resp_ready,
    output civ_pkg::out_item_t       resp
);

    localparam int AW      = $clog2(CAPACITY);
    localparam int LW      = $clog2(CAPACITY + 1);
    localparam int DW      = civ_pkg::DATA_W;
    localparam int LEN_RST = (civ_pkg::LEN_RESET < CAPACITY) ? civ_pkg::LEN_RESET : CAPACITY;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_DIV,
        S_EXEC,
        S_GET,
        S_MOVE,
        S_FINAL,
        S_FILL,
        S_RESP
    } state_t;

    state_t                      state_reg;
    logic [civ_pkg::OP_W-1:0]    op_reg;
    logic [DW-1:0]               value_reg;
    logic [AW-1:0]               pos_reg;
    logic [LW-1:0]               len_reg;
    logic [AW-1:0]               ptr_reg;
    logic [LW-1:0]               rd_left_reg;
    logic                        pend_reg;
    logic [AW-1:0]               pend_addr_reg;
    logic [civ_pkg::STAT_W-1:0]  status_reg;
    logic [DW-1:0]               rd_value_reg;

    // Entry memory with one write and one registered read port.
    logic [DW-1:0] mem [CAPACITY];
    logic [DW-1:0] rdata_reg;
    logic          we;
    logic [AW-1:0] waddr;
    logic [DW-1:0] wdata;
    logic          re;
    logic [AW-1:0] raddr;

    logic          accept;
    logic          negative;
    logic          is_insert;
    logic          div_start;
    logic          div_done;
    logic [LW-1:0] div_rem;
    logic [LW-1:0] cfg_len_clamped;

    // A length write in the same cycle takes precedence and holds off the item.
    assign accept    = req_valid && (state_reg == S_IDLE) && !cfg_we;
    assign negative  = req.index[DW-1];
    assign is_insert = (op_reg == civ_pkg::OP_INSERT);

    // Length register writes are clamped into the range one to the capacity.
    always_comb
    begin
        priority if (cfg_len == '0)
            cfg_len_clamped = LW'(1);
        else if (int'(cfg_len) > CAPACITY)
            cfg_len_clamped = LW'(CAPACITY);
        else
            cfg_len_clamped = LW'(cfg_len);
    end

    // Start the index reduction only for operations that reach the store at a position.
    always_comb
    begin
        div_start = 1'b0;
        if (accept && !negative)
        begin
            if (req.op == civ_pkg::OP_SET || req.op == civ_pkg::OP_GET)
                div_start = 1'b1;
            else if (req.op == civ_pkg::OP_INSERT && len_reg != LW'(CAPACITY))
                div_start = 1'b1;
            else if (req.op == civ_pkg::OP_DELETE && len_reg != LW'(1))
                div_start = 1'b1;
        end
    end

    civ_mod #(
        .LW (LW)
    ) u_civ_mod (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (req.index),
        .divisor   (len_reg),
        .done      (div_done),
        .remainder (div_rem)
    );

    // Memory port control for each state.
    always_comb
    begin
        we    = 1'b0;
        waddr = ptr_reg;
        wdata = '0;
        re    = 1'b0;
        raddr = pos_reg;
        unique case (state_reg)
            S_CLEAR:
            begin
                we = 1'b1;
            end
            S_EXEC:
            begin
                if (op_reg == civ_pkg::OP_SET)
                begin
                    we    = 1'b1;
                    waddr = pos_reg;
                    wdata = value_reg;
                end
                else if (op_reg == civ_pkg::OP_GET)
                begin
                    re = 1'b1;
                end
            end
            S_MOVE:
            begin
                re    = (rd_left_reg != '0);
                raddr = ptr_reg;
                we    = pend_reg;
                waddr = pend_addr_reg;
                wdata = rdata_reg;
            end
            S_FINAL:
            begin
                we    = 1'b1;
                waddr = is_insert ? pos_reg : AW'(len_reg - LW'(1));
                wdata = is_insert ? value_reg : '0;
            end
            S_FILL:
            begin
                we    = 1'b1;
                wdata = DW'(ptr_reg);
            end
            default:
            begin
                we = 1'b0;
            end
        endcase
    end

    // Memory array: synchronous write, registered read.
    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        if (re)
            rdata_reg <= mem[raddr];
    end

    // Sequencer: state, length in use and registered result fields.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            len_reg       <= LW'(LEN_RST);
            ptr_reg       <= '0;
            rd_left_reg   <= '0;
            pend_reg      <= 1'b0;
            op_reg        <= civ_pkg::OP_SET;
            status_reg    <= civ_pkg::ST_OK;
            pos_reg       <= '0;
            pend_addr_reg <= '0;
            value_reg     <= '0;
            rd_value_reg  <= '0;
        end
        else if (cfg_we)
        begin
            // A length write restarts the clearing pass over the whole store.
            len_reg   <= cfg_len_clamped;
            ptr_reg   <= '0;
            pend_reg  <= 1'b0;
            state_reg <= S_CLEAR;
        end
        else
        begin
            unique case (state_reg)
                S_CLEAR:
                begin
                    ptr_reg <= ptr_reg + AW'(1);
                    if (ptr_reg == AW'(CAPACITY - 1))
                        state_reg <= S_IDLE;
                end
                S_IDLE:
                begin
                    if (accept)
                    begin
                        op_reg       <= req.op;
                        value_reg    <= req.value;
                        rd_value_reg <= '0;
                        status_reg   <= civ_pkg::ST_OK;
                        ptr_reg      <= '0;
                        if (div_start)
                            state_reg <= S_DIV;
                        else if (req.op <= civ_pkg::OP_DELETE && negative)
                        begin
                            status_reg <= civ_pkg::ST_NEG;
                            state_reg  <= S_RESP;
                        end
                        else if (req.op == civ_pkg::OP_INSERT)
                        begin
                            status_reg <= civ_pkg::ST_FULL;
                            state_reg  <= S_RESP;
                        end
                        else if (req.op == civ_pkg::OP_DELETE)
                        begin
                            status_reg <= civ_pkg::ST_LAST;
                            state_reg  <= S_RESP;
                        end
                        else if (req.op == civ_pkg::OP_FILL)
                            state_reg <= S_FILL;
                        else
                            state_reg <= S_RESP;
                    end
                end
                S_DIV:
                begin
                    if (div_done)
                    begin
                        pos_reg   <= AW'(div_rem);
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    // Set writes, get reads; insert and delete prepare the shift.
                    pend_reg <= 1'b0;
                    if (op_reg == civ_pkg::OP_GET)
                        state_reg <= S_GET;
                    else if (op_reg == civ_pkg::OP_INSERT)
                    begin
                        ptr_reg     <= AW'(len_reg - LW'(1));
                        rd_left_reg <= len_reg - LW'(pos_reg);
                        state_reg   <= S_MOVE;
                    end
                    else if (op_reg == civ_pkg::OP_DELETE)
                    begin
                        ptr_reg     <= pos_reg + AW'(1);
                        rd_left_reg <= len_reg - LW'(1) - LW'(pos_reg);
                        state_reg   <= S_MOVE;
                    end
                    else
                        state_reg <= S_RESP;
                end
                S_GET:
                begin
                    rd_value_reg <= rdata_reg;
                    state_reg    <= S_RESP;
                end
                S_MOVE:
                begin
                    // Each entry is read one cycle and written one slot over the next.
                    if (rd_left_reg != '0)
                    begin
                        rd_left_reg   <= rd_left_reg - LW'(1);
                        pend_reg      <= 1'b1;
                        ptr_reg       <= is_insert ? ptr_reg - AW'(1) : ptr_reg + AW'(1);
                        pend_addr_reg <= is_insert ? ptr_reg + AW'(1) : ptr_reg - AW'(1);
                    end
                    else
                    begin
                        pend_reg <= 1'b0;
                        if (!pend_reg)
                            state_reg <= S_FINAL;
                    end
                end
                S_FINAL:
                begin
                    len_reg   <= is_insert ? len_reg + LW'(1) : len_reg - LW'(1);
                    state_reg <= S_RESP;
                end
                S_FILL:
                begin
                    ptr_reg <= ptr_reg + AW'(1);
                    if (LW'(ptr_reg) == len_reg - LW'(1))
                        state_reg <= S_RESP;
                end
                S_RESP:
                begin
                    if (resp_ready)
                        state_reg <= S_IDLE;
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign req_ready                = (state_reg == S_IDLE) && !cfg_we;
    assign resp_valid               = (state_reg == S_RESP);
    assign resp.read_value          = rd_value_reg;
    assign resp.current_length      = civ_pkg::LEN_W'(len_reg);
    assign resp.status              = status_reg;

endmodule

// File: src/cyclic_index_vector.sv
// cyclic_index_vector: top level of the cyclically indexed word store.
// Holds the result output register and the configuration port.
// Depends on civ_pkg and instantiates civ_core.
//
//   channel  | signals                              | direction
//   ---------+--------------------------------------+----------
//   item     | item_valid, item_ready, item         | in
//   result   | result_valid, result_ready, result   | out
//   cfg      | cfg_valid, cfg_ready, cfg_data       | in
//
// One transaction at a time. Error cases and unused codes go straight to the result; set
// and get first wait on the 32-step index reduction, and get then reads the entry; insert
// and delete also wait on it and then shift the tail of the store by one slot; fill
// writes each entry of the length in use. item_ready returns together with result_valid.
// After reset and after each length write a clearing pass over the whole store blocks items.
// A stalled result waits in the output register; a second one holds off the item channel.
module cyclic_index_vector #(
    parameter int CAPACITY = civ_pkg::CAPACITY_DEF
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      item_valid,
    output logic                      item_ready,
    input  civ_pkg::in_item_t         item,
    output logic                      result_valid,
    input  logic                      result_ready,
    output civ_pkg::out_item_t        result,
    input  logic                      cfg_valid,
    output logic                      cfg_ready,
    input  logic [civ_pkg::LEN_W-1:0] cfg_data
);

    logic               resp_valid;
    logic               resp_ready;
    civ_pkg::out_item_t resp;
    logic               result_valid_reg;
    civ_pkg::out_item_t result_reg;

    // Length writes are always taken.
    assign cfg_ready = 1'b1;

    civ_core #(
        .CAPACITY (CAPACITY)
    ) u_civ_core (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_we     (cfg_valid),
        .cfg_len    (cfg_data),
        .req_valid  (item_valid),
        .req_ready  (item_ready),
        .req        (item),
        .resp_valid (resp_valid),
        .resp_ready (resp_ready),
        .resp       (resp)
    );

    // Output register: loads whenever it is empty or being emptied.
    assign resp_ready = !result_valid_reg || result_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_valid_reg <= 1'b0;
        else if (resp_valid && resp_ready)
            result_valid_reg <= 1'b1;
        else if (result_ready)
            result_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (resp_valid && resp_ready)
            result_reg <= resp;
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

endmodule

// File: src/civ_checker.sv
// civ_checker: port-level assertions for cyclic_index_vector, with its bind.
// Watches the item, result and configuration channels over time.
// Depends on civ_pkg for the payload types and status codes.
module civ_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      item_valid,
    input logic                      item_ready,
    input civ_pkg::in_item_t         item,
    input logic                      result_valid,
    input logic                      result_ready,
    input civ_pkg::out_item_t        result,
    input logic                      cfg_valid,
    input logic                      cfg_ready,
    input logic [civ_pkg::LEN_W-1:0] cfg_data
);

    // A waiting result holds still until it is taken.
    a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(result))
        else $error("result changed while stalled");

    // The block works on one item at a time.
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        item_valid && item_ready |=> !item_ready)
        else $error("item taken while another is in progress");

    // A length write starts the clearing pass, which blocks new items.
    a_cfg_clear: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_valid && cfg_ready |=> !item_ready)
        else $error("item channel open right after a length write");

    // Only a successful operation can return a non-zero word.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != civ_pkg::ST_OK |-> result.read_value == '0)
        else $error("error result carries a read value");

endmodule

bind cyclic_index_vector civ_checker u_civ_checker (.*);
